// ===== rtl/core/fpa_pkg.sv =====
`default_nettype none
package fpa_pkg;

  // operation selector codes
  typedef enum logic [3:0] {
    KIND_ADD      = 4'd0,
    KIND_SUB      = 4'd1,
    KIND_MUL      = 4'd2,
    KIND_DIV      = 4'd3,
    KIND_INC      = 4'd4,
    KIND_DEC      = 4'd5,
    KIND_MIN      = 4'd6,
    KIND_MAX      = 4'd7,
    KIND_FROM_INT = 4'd8,
    KIND_TO_INT   = 4'd9
  } kind_t;

  localparam int unsigned DATA_W = 32;

  // per-beat sideband that runs beside the divider
  typedef struct packed {
    logic [DATA_W-1:0] res;
    logic              is_div;
    logic              neg;
    logic              dz;
    logic              is_less;
    logic              is_equal;
    logic              is_greater;
  } side_t;

endpackage
`default_nettype wire

// ===== rtl/core/fpa_if.sv =====
`default_nettype none
interface fpa_in_if;
  logic        valid;
  logic        ready;
  logic [3:0]  kind;
  logic signed [31:0] operand_a;
  logic signed [31:0] operand_b;
  modport source (output valid, kind, operand_a, operand_b, input ready);
  modport sink   (input valid, kind, operand_a, operand_b, output ready);
endinterface

interface fpa_out_if;
  logic        valid;
  logic        ready;
  logic signed [31:0] result_value;
  logic        is_less;
  logic        is_equal;
  logic        is_greater;
  logic        divide_by_zero;
  modport source (output valid, result_value, is_less, is_equal, is_greater,
                  divide_by_zero, input ready);
  modport sink   (input valid, result_value, is_less, is_equal, is_greater,
                  divide_by_zero, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/fpa_front.sv =====
`default_nettype none
module fpa_front #(
  parameter int unsigned FRAC_BITS = 8
) (
  input  wire logic        clk,
  input  wire logic        en,
  input  wire logic [3:0]  kind,
  input  wire logic [31:0] operand_a,
  input  wire logic [31:0] operand_b,
  output fpa_pkg::side_t   side
);

  logic [3:0]         kind_q;
  logic signed [31:0] a_q;
  logic signed [31:0] b_q;
  logic signed [63:0] prod_q;
  logic signed [63:0] prod_sh;
  fpa_pkg::side_t     side_next;

  // stage one: operands and the full signed product
  always_ff @(posedge clk) begin
    if (en) begin
      kind_q <= kind;
      a_q    <= operand_a;
      b_q    <= operand_b;
      prod_q <= 64'($signed(operand_a)) * 64'($signed(operand_b));
    end
  end

  assign prod_sh = prod_q >>> FRAC_BITS;

  // stage two: every result but the quotient
  always_comb begin
    side_next            = '0;
    side_next.is_less    = a_q < b_q;
    side_next.is_equal   = a_q == b_q;
    side_next.is_greater = a_q > b_q;
    side_next.neg        = a_q[31] ^ b_q[31];
    case (kind_q)
      fpa_pkg::KIND_ADD:      side_next.res = a_q + b_q;
      fpa_pkg::KIND_SUB:      side_next.res = a_q - b_q;
      fpa_pkg::KIND_MUL:      side_next.res = prod_sh[31:0];
      fpa_pkg::KIND_DIV: begin
        side_next.is_div = 1'b1;
        side_next.dz     = b_q == 32'sd0;
      end
      fpa_pkg::KIND_INC:      side_next.res = a_q + 32'sd1;
      fpa_pkg::KIND_DEC:      side_next.res = a_q - 32'sd1;
      fpa_pkg::KIND_MIN:      side_next.res = (a_q < b_q) ? a_q : b_q;
      fpa_pkg::KIND_MAX:      side_next.res = (a_q > b_q) ? a_q : b_q;
      fpa_pkg::KIND_FROM_INT: side_next.res = a_q << FRAC_BITS;
      fpa_pkg::KIND_TO_INT:   side_next.res = a_q >>> FRAC_BITS;
      default:                side_next.res = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side <= side_next;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/fpa_divider.sv =====
`default_nettype none
module fpa_divider #(
  parameter int unsigned FRAC_BITS = 8
) (
  input  wire logic        clk,
  input  wire logic        en,
  input  wire logic [31:0] operand_a,
  input  wire logic [31:0] operand_b,
  output logic [31:0]      quotient
);

  localparam int unsigned W = 32 + FRAC_BITS;

  logic [31:0]  mag_a;
  logic [31:0]  mag_b;
  logic [31:0]  rem_q  [0:W];
  logic [W-1:0] dq_q   [0:W];
  logic [31:0]  div_q  [0:W];
  logic [32:0]  trial  [0:W-1];
  logic         ge     [0:W-1];

  assign mag_a = operand_a[31] ? (32'd0 - operand_a) : operand_a;
  assign mag_b = operand_b[31] ? (32'd0 - operand_b) : operand_b;

  // one restoring step per stage, one quotient bit each
  always_comb begin
    for (int i = 0; i < W; i++) begin
      trial[i] = {rem_q[i], dq_q[i][W-1]};
      ge[i]    = trial[i] >= {1'b0, div_q[i]};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_q[0] <= '0;
      dq_q[0]  <= {mag_a, {FRAC_BITS{1'b0}}};
      div_q[0] <= mag_b;
      for (int i = 0; i < W; i++) begin
        rem_q[i+1] <= ge[i] ? 32'(trial[i] - {1'b0, div_q[i]}) : trial[i][31:0];
        dq_q[i+1]  <= {dq_q[i][W-2:0], ge[i]};
        div_q[i+1] <= div_q[i];
      end
    end
  end

  assign quotient = dq_q[W][31:0];

endmodule
`default_nettype wire

// ===== rtl/core/fixed_point_alu_top.sv =====
`default_nettype none
// channel  | dir | payload
// in_ch    | in  | kind, operand_a, operand_b
// out_ch   | out | result_value, is_less, is_equal, is_greater, divide_by_zero
//
// one beat per cycle in and out while the output is not stalled; depth is set by the
// divider, which resolves one quotient bit per stage over 32 + FRAC_BITS stages.
// rst clears only the valid bits of the pipeline.
// a stall at the output freezes the whole pipeline; empty slots are not skipped.
module fixed_point_alu_top #(
  parameter int unsigned FRAC_BITS = 8
) (
  input wire logic   clk,
  input wire logic   rst,
  fpa_in_if.sink     in_ch,
  fpa_out_if.source  out_ch
);

  localparam int unsigned W   = 32 + FRAC_BITS;
  localparam int unsigned LAT = W + 2;

  logic           en;
  logic           vld [0:LAT-1];
  fpa_pkg::side_t side_s2;
  fpa_pkg::side_t side_d [0:W-2];
  logic [31:0]    quot;
  logic [31:0]    res_next;
  fpa_pkg::side_t side_last;

  assign en          = !vld[LAT-1] || out_ch.ready;
  assign in_ch.ready = en;

  // valid bits travel with the data
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < LAT; i++) vld[i] <= 1'b0;
    end else if (en) begin
      vld[0] <= in_ch.valid;
      for (int i = 1; i < LAT; i++) vld[i] <= vld[i-1];
    end
  end

  fpa_front #(.FRAC_BITS(FRAC_BITS)) u_front (
    .clk       (clk),
    .en        (en),
    .kind      (in_ch.kind),
    .operand_a (in_ch.operand_a),
    .operand_b (in_ch.operand_b),
    .side      (side_s2)
  );

  fpa_divider #(.FRAC_BITS(FRAC_BITS)) u_div (
    .clk       (clk),
    .en        (en),
    .operand_a (in_ch.operand_a),
    .operand_b (in_ch.operand_b),
    .quotient  (quot)
  );

  // delay line aligning the sideband with the quotient
  always_ff @(posedge clk) begin
    if (en) begin
      side_d[0] <= side_s2;
      for (int i = 1; i < W - 1; i++) side_d[i] <= side_d[i-1];
    end
  end

  assign side_last = side_d[W-2];

  // final select: sign and zero-divisor handling of the quotient
  always_comb begin
    res_next = side_last.res;
    if (side_last.is_div) begin
      if (side_last.dz) res_next = '0;
      else if (side_last.neg) res_next = 32'd0 - quot;
      else res_next = quot;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_ch.result_value   <= res_next;
      out_ch.is_less        <= side_last.is_less;
      out_ch.is_equal       <= side_last.is_equal;
      out_ch.is_greater     <= side_last.is_greater;
      out_ch.divide_by_zero <= side_last.is_div && side_last.dz;
    end
  end

  assign out_ch.valid = vld[LAT-1];

endmodule
`default_nettype wire
